FILE: hdl/lca_pkg.sv
// ----------------------------------------------------------------------------
// lca_pkg
// Shared constants, codes and controller/datapath handshake types for the
// lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
`default_nettype none

package lca_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int LIFT_LEVELS = 10;
  localparam int EDGE_SLOTS  = 2 * (MAX_NODES - 1);

  localparam int NODE_W     = $clog2(MAX_NODES + 1);
  localparam int DEPTH_W    = $clog2(MAX_NODES);
  localparam int SLOT_W     = $clog2(EDGE_SLOTS + 1);
  localparam int LVL_W      = $clog2(LIFT_LEVELS + 1);
  localparam int HEAD_DEPTH = MAX_NODES + 1;
  localparam int QUEUE_AW   = $clog2(MAX_NODES);
  localparam int QUEUE_W    = DEPTH_W + NODE_W;
  localparam int ANC_AW     = LVL_W + NODE_W;
  localparam int ANC_DEPTH  = LIFT_LEVELS * (2 ** NODE_W);

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int REG_NODE_COUNT = 0;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_BUILD = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_BAD_ID    = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_BUILT = 2'd3
  } sts_t;

  typedef enum logic [5:0] {
    ST_INIT, ST_IDLE, ST_DECODE, ST_CLR,
    ST_ADD_RA, ST_ADD_WA, ST_ADD_RB, ST_ADD_WB,
    ST_BCLR, ST_BINIT, ST_BDQ, ST_BDQ_W, ST_BHEAD, ST_BLINK, ST_BLINK_W, ST_BSEEN,
    ST_FINIT, ST_FRD1, ST_FRD2, ST_FWR,
    ST_QDA, ST_QDB, ST_QSW, ST_QLIFT, ST_QLIFT_W, ST_QCMP,
    ST_QUP, ST_QUP_U, ST_QUP_V, ST_QTOP, ST_QTOP_W,
    ST_FIN
  } state_t;

  typedef enum logic [5:0] {
    OP_NONE, OP_ACCEPT, OP_DECODE, OP_HCLR,
    OP_ADD_RA, OP_ADD_WA, OP_ADD_RB, OP_ADD_WB,
    OP_BCLR, OP_BINIT, OP_BDQ, OP_BDQ_W, OP_BHEAD, OP_BLINK, OP_BLINK_W, OP_BSEEN,
    OP_FINIT, OP_FRD1, OP_FRD2, OP_FWR,
    OP_QDA, OP_QDB, OP_QSW, OP_QLIFT, OP_QLIFT_W, OP_QCMP,
    OP_QUP, OP_QUP_U, OP_QUP_V, OP_QTOP, OP_QTOP_W,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } lca_ctl_t;

  typedef struct packed {
    logic in_fire;
    cmd_t cmd_code;
    logic decode_ok;
    logic sweep_last;
    logic queue_empty;
    logic link_end;
    logic lift_done;
    logic diff_bit;
    logic same_node;
    logic level_zero;
    logic fill_last;
    logic out_free;
  } lca_stat_t;

endpackage

`default_nettype wire

FILE: hdl/lca_if.sv
// ----------------------------------------------------------------------------
// lca_if
// Command and response channels of the lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface lca_cmd_if;
  import lca_pkg::*;
  logic              valid;
  logic              ready;
  cmd_t              command;
  logic [NODE_W-1:0] node_a;
  logic [NODE_W-1:0] node_b;
  modport source (output valid, command, node_a, node_b, input ready);
  modport sink   (input valid, command, node_a, node_b, output ready);
endinterface

interface lca_rsp_if;
  import lca_pkg::*;
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] ancestor_node;
  sts_t              status;
  modport source (output valid, ancestor_node, status, input ready);
  modport sink   (input valid, ancestor_node, status, output ready);
endinterface

`default_nettype wire

FILE: hdl/lca_ram.sv
// ----------------------------------------------------------------------------
// lca_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/lca_ctrl.sv
// ----------------------------------------------------------------------------
// lca_ctrl
// Sequencer: steps the datapath through clear, add, build and query.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire lca_pkg::lca_stat_t stat,
  output lca_pkg::lca_ctl_t       ctl
);
  import lca_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_INIT:    if (stat.sweep_last) state_next = ST_IDLE;
      ST_IDLE:    if (stat.in_fire) state_next = ST_DECODE;
      ST_DECODE: begin
        case (stat.cmd_code)
          CMD_CLEAR: state_next = ST_CLR;
          CMD_ADD:   state_next = stat.decode_ok ? ST_ADD_RA : ST_FIN;
          CMD_BUILD: state_next = ST_BCLR;
          CMD_QUERY: state_next = stat.decode_ok ? ST_QDA : ST_FIN;
          default:   state_next = ST_FIN;
        endcase
      end
      ST_CLR:     if (stat.sweep_last) state_next = ST_FIN;
      ST_ADD_RA:  state_next = ST_ADD_WA;
      ST_ADD_WA:  state_next = ST_ADD_RB;
      ST_ADD_RB:  state_next = ST_ADD_WB;
      ST_ADD_WB:  state_next = ST_FIN;
      ST_BCLR:    if (stat.sweep_last) state_next = ST_BINIT;
      ST_BINIT:   state_next = ST_BDQ;
      ST_BDQ:     state_next = stat.queue_empty ? ST_FINIT : ST_BDQ_W;
      ST_BDQ_W:   state_next = ST_BHEAD;
      ST_BHEAD:   state_next = ST_BLINK;
      ST_BLINK:   state_next = stat.link_end ? ST_BDQ : ST_BLINK_W;
      ST_BLINK_W: state_next = ST_BSEEN;
      ST_BSEEN:   state_next = ST_BLINK;
      ST_FINIT:   state_next = ST_FRD1;
      ST_FRD1:    state_next = ST_FRD2;
      ST_FRD2:    state_next = ST_FWR;
      ST_FWR:     state_next = stat.fill_last ? ST_FIN : ST_FRD1;
      ST_QDA:     state_next = ST_QDB;
      ST_QDB:     state_next = ST_QSW;
      ST_QSW:     state_next = ST_QLIFT;
      ST_QLIFT: begin
        if (stat.lift_done) state_next = ST_QCMP;
        else if (stat.diff_bit) state_next = ST_QLIFT_W;
      end
      ST_QLIFT_W: state_next = ST_QLIFT;
      ST_QCMP:    state_next = stat.same_node ? ST_FIN : ST_QUP;
      ST_QUP:     state_next = ST_QUP_U;
      ST_QUP_U:   state_next = ST_QUP_V;
      ST_QUP_V:   state_next = stat.level_zero ? ST_QTOP : ST_QUP;
      ST_QTOP:    state_next = ST_QTOP_W;
      ST_QTOP_W:  state_next = ST_FIN;
      ST_FIN:     if (stat.out_free) state_next = ST_IDLE;
      default:    state_next = ST_INIT;
    endcase
  end

  always_comb begin
    case (state)
      ST_INIT:    ctl.op = OP_HCLR;
      ST_IDLE:    ctl.op = OP_ACCEPT;
      ST_DECODE:  ctl.op = OP_DECODE;
      ST_CLR:     ctl.op = OP_HCLR;
      ST_ADD_RA:  ctl.op = OP_ADD_RA;
      ST_ADD_WA:  ctl.op = OP_ADD_WA;
      ST_ADD_RB:  ctl.op = OP_ADD_RB;
      ST_ADD_WB:  ctl.op = OP_ADD_WB;
      ST_BCLR:    ctl.op = OP_BCLR;
      ST_BINIT:   ctl.op = OP_BINIT;
      ST_BDQ:     ctl.op = OP_BDQ;
      ST_BDQ_W:   ctl.op = OP_BDQ_W;
      ST_BHEAD:   ctl.op = OP_BHEAD;
      ST_BLINK:   ctl.op = OP_BLINK;
      ST_BLINK_W: ctl.op = OP_BLINK_W;
      ST_BSEEN:   ctl.op = OP_BSEEN;
      ST_FINIT:   ctl.op = OP_FINIT;
      ST_FRD1:    ctl.op = OP_FRD1;
      ST_FRD2:    ctl.op = OP_FRD2;
      ST_FWR:     ctl.op = OP_FWR;
      ST_QDA:     ctl.op = OP_QDA;
      ST_QDB:     ctl.op = OP_QDB;
      ST_QSW:     ctl.op = OP_QSW;
      ST_QLIFT:   ctl.op = OP_QLIFT;
      ST_QLIFT_W: ctl.op = OP_QLIFT_W;
      ST_QCMP:    ctl.op = OP_QCMP;
      ST_QUP:     ctl.op = OP_QUP;
      ST_QUP_U:   ctl.op = OP_QUP_U;
      ST_QUP_V:   ctl.op = OP_QUP_V;
      ST_QTOP:    ctl.op = OP_QTOP;
      ST_QTOP_W:  ctl.op = OP_QTOP_W;
      ST_FIN:     ctl.op = OP_EMIT;
      default:    ctl.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/lca_datapath.sv
// ----------------------------------------------------------------------------
// lca_datapath
// Edge store, walk queue, depth and ancestor memories, working registers
// and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst,
  lca_cmd_if.sink                        cmd,
  lca_rsp_if.source                      rsp,
  input  wire logic                      cfg_we,
  input  wire logic [lca_pkg::NODE_W-1:0] cfg_data,
  output logic      [lca_pkg::NODE_W-1:0] node_count,
  input  wire lca_pkg::lca_ctl_t         ctl,
  output lca_pkg::lca_stat_t             stat
);
  import lca_pkg::*;

  cmd_t               cmd_r;
  logic [NODE_W-1:0]  a_r, b_r;
  logic [SLOT_W-1:0]  edge_used;
  logic               tables_ready;
  logic [NODE_W-1:0]  idx;
  logic [NODE_W-1:0]  q_rd, q_wr;
  logic [NODE_W-1:0]  cur, nb, link, u, v, tu;
  logic [DEPTH_W-1:0] cur_depth, du, diff;
  logic [LVL_W-1:0]   lvl;
  logic [NODE_W-1:0]  res_node;
  sts_t               res_status;
  logic               ov;
  logic [NODE_W-1:0]  o_node;
  sts_t               o_status;

  logic [NODE_W-1:0]  n_use;
  logic               ids_ok, store_full, take;
  logic [DEPTH_W-1:0] diff_sh, dv;
  logic [LVL_W-1:0]   lvl_m1;
  logic [SLOT_W-1:0]  slot0, slot1, slot2, link_slot;
  logic [DEPTH_W-1:0] depth_inc;

  logic                  head_we, next_we, tgt_we, node_we, q_we, anc_we;
  logic [NODE_W-1:0]     head_wa, head_ra, head_wd, head_rd;
  logic [SLOT_W-1:0]     edge_wa, edge_ra;
  logic [NODE_W-1:0]     next_wd, next_rd, tgt_wd, tgt_rd;
  logic [NODE_W-1:0]     node_wa, node_ra, node_wd, node_rd;
  logic [QUEUE_AW-1:0]   q_wa, q_ra;
  logic [QUEUE_W-1:0]    q_wd, q_rdata;
  logic [ANC_AW-1:0]     anc_wa, anc_ra;
  logic [NODE_W-1:0]     anc_wd, anc_rd;

  assign n_use = (node_count == '0) ? NODE_W'(1) :
                 (node_count > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count;
  assign ids_ok = (a_r != '0) && (a_r <= n_use) && (b_r != '0) && (b_r <= n_use);
  assign store_full = ({1'b0, edge_used} + (SLOT_W + 1)'(2)) > (SLOT_W + 1)'(EDGE_SLOTS);
  assign slot0 = edge_used;
  assign slot1 = edge_used + SLOT_W'(1);
  assign slot2 = edge_used + SLOT_W'(2);
  assign link_slot = SLOT_W'(link - NODE_W'(1));
  assign lvl_m1 = lvl - LVL_W'(1);
  assign diff_sh = diff >> lvl;
  assign depth_inc = cur_depth + DEPTH_W'(1);
  assign dv = node_rd[DEPTH_W-1:0];
  assign take = (nb <= NODE_W'(MAX_NODES)) && !node_rd[DEPTH_W]
                && (q_wr < NODE_W'(MAX_NODES));

  always_comb begin
    stat.in_fire     = cmd.valid && cmd.ready;
    stat.cmd_code    = cmd_r;
    case (cmd_r)
      CMD_ADD:   stat.decode_ok = ids_ok && !store_full;
      CMD_QUERY: stat.decode_ok = ids_ok && tables_ready;
      default:   stat.decode_ok = 1'b1;
    endcase
    stat.sweep_last  = (idx == NODE_W'(MAX_NODES));
    stat.queue_empty = (q_rd == q_wr);
    stat.link_end    = (link == '0) || (link > NODE_W'(EDGE_SLOTS));
    stat.lift_done   = (lvl == LVL_W'(LIFT_LEVELS));
    stat.diff_bit    = (lvl < LVL_W'(LIFT_LEVELS)) && diff_sh[0];
    stat.same_node   = (u == v);
    stat.level_zero  = (lvl == '0);
    stat.fill_last   = (idx == NODE_W'(MAX_NODES)) && (lvl == LVL_W'(LIFT_LEVELS - 1));
    stat.out_free    = !ov || rsp.ready;
  end

  assign cmd.ready         = (ctl.op == OP_ACCEPT);
  assign rsp.valid         = ov;
  assign rsp.ancestor_node = o_node;
  assign rsp.status        = o_status;

  always_comb begin
    head_we = 1'b0; head_wa = idx;  head_wd = '0; head_ra = a_r;
    next_we = 1'b0; tgt_we  = 1'b0; edge_wa = slot0; edge_ra = link_slot;
    next_wd = head_rd; tgt_wd = b_r;
    node_we = 1'b0; node_wa = idx;  node_wd = '0; node_ra = a_r;
    q_we    = 1'b0; q_wa = q_wr[QUEUE_AW-1:0]; q_wd = {depth_inc, nb};
    q_ra    = q_rd[QUEUE_AW-1:0];
    anc_we  = 1'b0; anc_wa = {lvl, idx}; anc_wd = anc_rd; anc_ra = {lvl, u};
    case (ctl.op)
      OP_HCLR: head_we = 1'b1;
      OP_ADD_RA: head_ra = a_r;
      OP_ADD_WA: begin
        tgt_we = 1'b1; next_we = 1'b1;
        head_we = 1'b1; head_wa = a_r; head_wd = NODE_W'(slot1);
      end
      OP_ADD_RB: head_ra = b_r;
      OP_ADD_WB: begin
        tgt_we = 1'b1; next_we = 1'b1; edge_wa = slot1; tgt_wd = a_r;
        head_we = 1'b1; head_wa = b_r; head_wd = NODE_W'(slot2);
      end
      OP_BCLR: begin
        node_we = 1'b1;
        anc_we = 1'b1; anc_wa = {LVL_W'(0), idx}; anc_wd = '0;
      end
      OP_BINIT: begin
        node_we = 1'b1; node_wa = NODE_W'(1); node_wd = {1'b1, DEPTH_W'(0)};
        q_we = 1'b1; q_wa = '0; q_wd = {DEPTH_W'(0), NODE_W'(1)};
      end
      OP_BDQ_W: head_ra = q_rdata[NODE_W-1:0];
      OP_BLINK_W: node_ra = tgt_rd;
      OP_BSEEN: begin
        if (take) begin
          node_we = 1'b1; node_wa = nb; node_wd = {1'b1, depth_inc};
          anc_we = 1'b1; anc_wa = {LVL_W'(0), nb}; anc_wd = cur;
          q_we = 1'b1;
        end
      end
      OP_FRD1: anc_ra = {lvl_m1, idx};
      OP_FRD2: anc_ra = {lvl_m1, anc_rd};
      OP_FWR:  anc_we = 1'b1;
      OP_QDA:  node_ra = a_r;
      OP_QDB:  node_ra = b_r;
      OP_QUP_U: anc_ra = {lvl, v};
      OP_QTOP: anc_ra = {LVL_W'(0), u};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count   <= NODE_W'(1);
      edge_used    <= '0;
      tables_ready <= 1'b0;
      idx          <= '0;
      ov           <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_data;
      end
      if (ctl.op == OP_EMIT && stat.out_free) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      case (ctl.op)
        OP_HCLR, OP_BCLR: idx <= stat.sweep_last ? '0 : idx + NODE_W'(1);
        OP_DECODE: begin
          if (cmd_r == CMD_CLEAR) begin
            edge_used <= '0;
            tables_ready <= 1'b0;
          end
          if (cmd_r == CMD_BUILD) begin
            tables_ready <= 1'b0;
          end
        end
        OP_ADD_WB: begin
          edge_used <= slot2;
          tables_ready <= 1'b0;
        end
        OP_FINIT: idx <= '0;
        OP_FWR: begin
          idx <= stat.sweep_last ? '0 : idx + NODE_W'(1);
          if (stat.fill_last) begin
            tables_ready <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_EMIT && stat.out_free) begin
      o_node   <= res_node;
      o_status <= res_status;
    end
    case (ctl.op)
      OP_ACCEPT: begin
        if (stat.in_fire) begin
          cmd_r <= cmd.command;
          a_r   <= cmd.node_a;
          b_r   <= cmd.node_b;
        end
      end
      OP_DECODE: begin
        res_node   <= '0;
        res_status <= STS_OK;
        if (cmd_r == CMD_ADD) begin
          if (!ids_ok) res_status <= STS_BAD_ID;
          else if (store_full) res_status <= STS_FULL;
        end else if (cmd_r == CMD_QUERY) begin
          if (!ids_ok) res_status <= STS_BAD_ID;
          else if (!tables_ready) res_status <= STS_NOT_BUILT;
        end
      end
      OP_BINIT: begin
        q_rd <= '0;
        q_wr <= NODE_W'(1);
      end
      OP_BDQ_W: begin
        cur       <= q_rdata[NODE_W-1:0];
        cur_depth <= q_rdata[QUEUE_W-1:NODE_W];
        q_rd      <= q_rd + NODE_W'(1);
      end
      OP_BHEAD: link <= head_rd;
      OP_BLINK_W: begin
        nb   <= tgt_rd;
        link <= next_rd;
      end
      OP_BSEEN: if (take) q_wr <= q_wr + NODE_W'(1);
      OP_FINIT: lvl <= LVL_W'(1);
      OP_FWR: if (stat.sweep_last) lvl <= lvl + LVL_W'(1);
      OP_QDB: du <= dv;
      OP_QSW: begin
        lvl <= '0;
        if (du < dv) begin
          u <= b_r; v <= a_r; diff <= dv - du;
        end else begin
          u <= a_r; v <= b_r; diff <= du - dv;
        end
      end
      OP_QLIFT: if (!stat.lift_done && !stat.diff_bit) lvl <= lvl + LVL_W'(1);
      OP_QLIFT_W: begin
        u   <= anc_rd;
        lvl <= lvl + LVL_W'(1);
      end
      OP_QCMP: begin
        lvl <= LVL_W'(LIFT_LEVELS - 1);
        if (stat.same_node) res_node <= u;
      end
      OP_QUP_U: tu <= anc_rd;
      OP_QUP_V: begin
        if (tu != anc_rd) begin
          u <= tu;
          v <= anc_rd;
        end
        if (!stat.level_zero) lvl <= lvl - LVL_W'(1);
      end
      OP_QTOP_W: res_node <= anc_rd;
      default: ;
    endcase
  end

  lca_ram #(.WIDTH(NODE_W), .DEPTH(HEAD_DEPTH)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd));

  lca_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_SLOTS)) u_next (
    .clk(clk), .we(next_we), .waddr(edge_wa), .wdata(next_wd),
    .raddr(edge_ra), .rdata(next_rd));

  lca_ram #(.WIDTH(NODE_W), .DEPTH(EDGE_SLOTS)) u_tgt (
    .clk(clk), .we(tgt_we), .waddr(edge_wa), .wdata(tgt_wd),
    .raddr(edge_ra), .rdata(tgt_rd));

  lca_ram #(.WIDTH(DEPTH_W + 1), .DEPTH(HEAD_DEPTH)) u_node (
    .clk(clk), .we(node_we), .waddr(node_wa), .wdata(node_wd[DEPTH_W:0]),
    .raddr(node_ra), .rdata(node_rd[DEPTH_W:0]));

  lca_ram #(.WIDTH(QUEUE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_wa), .wdata(q_wd),
    .raddr(q_ra), .rdata(q_rdata));

  lca_ram #(.WIDTH(NODE_W), .DEPTH(ANC_DEPTH)) u_anc (
    .clk(clk), .we(anc_we), .waddr(anc_wa), .wdata(anc_wd),
    .raddr(anc_ra), .rdata(anc_rd));

endmodule

`default_nettype wire

FILE: hdl/tree_lca_binary_lifting.sv
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting
// Tree store with breadth-first build and binary-lifting ancestor queries.
// ----------------------------------------------------------------------------
// One command is worked at a time and every command returns one response beat.
// After reset the head table is swept before the first command is taken; a
// clear command repeats that sweep. A query makes two depth reads, a pass over
// all levels with one extra ancestor-memory read per set bit of the depth
// difference, and, unless the lifted nodes already match, reads of both
// ancestors at each level on the way up, all through the single read port of
// that memory. A build clears the depth and level-zero ancestor tables, walks
// the reached nodes and their directed edges breadth-first, then fills the
// levels with two reads per node slot per level. The response register holds
// a finished beat while the next command is taken.
`default_nettype none

module tree_lca_binary_lifting (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lca_cmd_if.sink                         cmd,
  lca_rsp_if.source                       rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [lca_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lca_pkg::DATA_W-1:0] pwdata,
  output logic      [lca_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);
  import lca_pkg::*;

  lca_ctl_t          ctl;
  lca_stat_t         stat;
  logic              cfg_we;
  logic [NODE_W-1:0] node_count;
  logic              reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == (ADDR_W - 2)'(REG_NODE_COUNT));
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign prdata  = reg_hit ? DATA_W'(node_count) : '0;

  lca_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .ctl(ctl));

  lca_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_data(pwdata[NODE_W-1:0]), .node_count(node_count),
    .ctl(ctl), .stat(stat));

endmodule

`default_nettype wire

FILE: hdl/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_checker
// Port-level checks of the lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      cmd_valid,
  input wire logic                      cmd_ready,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic [lca_pkg::NODE_W-1:0] rsp_node,
  input wire logic [1:0]                rsp_status
);
  import lca_pkg::*;

  a_init_sweep: assert property (@(posedge clk) rst |=> !cmd_ready)
    else $error("command taken right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("command taken while one is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_node) && $stable(rsp_status))
    else $error("stalled response beat changed");

  a_err_no_node: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != STS_OK) |-> (rsp_node == '0))
    else $error("error beat carries a node");

  a_node_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_node <= NODE_W'(MAX_NODES)))
    else $error("ancestor node out of range");

endmodule

bind tree_lca_binary_lifting lca_checker u_lca_checker (
  .clk(clk), .rst(rst),
  .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_node(rsp.ancestor_node), .rsp_status(rsp.status));

`default_nettype wire

FILE: tb/lca_checker.sv
// ----------------------------------------------------------------------------
// lca_scoreboard
// Watches the command, response and register ports of the LCA engine, keeps
// its own copy of the tree store and ancestor tables, and compares every
// response beat against the predicted answer in order.
// ----------------------------------------------------------------------------
`default_nettype none

module lca_scoreboard (
  input  wire logic                       clk,
  input  wire logic                       rst,
  lca_cmd_if                              cmd,
  lca_rsp_if                              rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic                       pready,
  input  wire logic [lca_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lca_pkg::DATA_W-1:0] pwdata,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import lca_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] anc;
    sts_t              st;
  } lca_answer_t;

  lca_answer_t       answers[$];
  bit [NODE_W-1:0]   cfg_nodes;
  bit [NODE_W-1:0]   head[HEAD_DEPTH];
  bit [NODE_W-1:0]   link_next[EDGE_SLOTS];
  bit [NODE_W-1:0]   link_dest[EDGE_SLOTS];
  bit [NODE_W-1:0]   slots_used;
  bit [DEPTH_W-1:0]  depth[HEAD_DEPTH];
  bit                seen[HEAD_DEPTH];
  bit [NODE_W-1:0]   up[LIFT_LEVELS][HEAD_DEPTH];
  bit [NODE_W-1:0]   bfs[MAX_NODES];
  bit                built;

  initial errors = 0;

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic void clear_store();
    foreach (head[i]) head[i] = '0;
    slots_used = '0;
    built = 1'b0;
  endfunction

  function automatic void build_tree();
    int rd, wr, cur, lnk, nb;
    rd = 0;
    wr = 0;
    foreach (depth[i]) begin
      depth[i] = '0;
      seen[i] = 1'b0;
    end
    foreach (up[k, v]) up[k][v] = '0;
    seen[1] = 1'b1;
    bfs[wr++] = 1;
    while (rd < wr) begin
      cur = bfs[rd++];
      lnk = head[cur];
      while (lnk != 0 && lnk <= EDGE_SLOTS) begin
        nb = link_dest[lnk-1];
        if (nb <= MAX_NODES && !seen[nb] && wr < MAX_NODES) begin
          seen[nb] = 1'b1;
          up[0][nb] = cur;
          depth[nb] = depth[cur] + 1'b1;
          bfs[wr++] = nb;
        end
        lnk = link_next[lnk-1];
      end
    end
    for (int k = 1; k < LIFT_LEVELS; k++)
      for (int v = 1; v <= MAX_NODES; v++) up[k][v] = up[k-1][up[k-1][v]];
    built = 1'b1;
  endfunction

  function automatic bit [NODE_W-1:0] common_root(input int u, input int v);
    int t;
    bit [DEPTH_W-1:0] diff;
    if (depth[u] < depth[v]) begin
      t = u; u = v; v = t;
    end
    diff = depth[u] - depth[v];
    for (int k = 0; k < LIFT_LEVELS; k++)
      if (diff[k]) u = up[k][u];
    if (u == v) return u;
    for (int k = LIFT_LEVELS - 1; k >= 0; k--) begin
      if (up[k][u] != up[k][v]) begin
        u = up[k][u];
        v = up[k][v];
      end
    end
    return up[0][u];
  endfunction

  function automatic lca_answer_t apply_cmd(input cmd_t c, input int a, input int b);
    lca_answer_t r;
    int n, s;
    bit ids_ok;
    r.anc = '0;
    r.st = STS_OK;
    n = (cfg_nodes == 0) ? 1 : (cfg_nodes > MAX_NODES) ? MAX_NODES : cfg_nodes;
    ids_ok = a >= 1 && a <= n && b >= 1 && b <= n;
    case (c)
      CMD_CLEAR: clear_store();
      CMD_ADD: begin
        if (!ids_ok) r.st = STS_BAD_ID;
        else if (slots_used + 2 > EDGE_SLOTS) r.st = STS_FULL;
        else begin
          s = slots_used;
          link_dest[s] = b;
          link_next[s] = head[a];
          head[a] = s + 1;
          link_dest[s+1] = a;
          link_next[s+1] = head[b];
          head[b] = s + 2;
          slots_used = s + 2;
          built = 1'b0;
        end
      end
      CMD_BUILD: build_tree();
      default: begin
        if (!ids_ok) r.st = STS_BAD_ID;
        else if (!built) r.st = STS_NOT_BUILT;
        else r.anc = common_root(a, b);
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    lca_answer_t want;
    if (rst) begin
      cfg_nodes = 1;
      clear_store();
      answers.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_W'(REG_NODE_COUNT * 4))
        cfg_nodes = pwdata[NODE_W-1:0];
      if (cmd.valid && cmd.ready)
        answers = {answers, apply_cmd(cmd.command, cmd.node_a, cmd.node_b)};
      if (rsp.valid && rsp.ready) begin
        if (answers.size() == 0) begin
          report("response beat with nothing expected");
        end else begin
          want = answers.pop_front();
          if (rsp.ancestor_node !== want.anc)
            report($sformatf("ancestor_node %0d, want %0d", rsp.ancestor_node, want.anc));
          if (rsp.status !== want.st)
            report($sformatf("status %0d, want %0d", rsp.status, want.st));
        end
      end
    end
    pending = answers.size();
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives tree commands and node-count writes into the LCA engine: a directed
// pass over the corner cases, a full edge store on a deep 1024-node tree, then
// random trees with random queries, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lca_pkg::*;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                errors;
  int                pending;
  bit                jitter;
  int                hold_left;

  lca_cmd_if cmd ();
  lca_rsp_if rsp ();

  tree_lca_binary_lifting uut (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lca_scoreboard chk (
    .clk(clk), .rst(rst), .cmd(cmd), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #36ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rsp.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else if (jitter && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 16) - 1;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  task automatic issue(input cmd_t c, input int a, input int b);
    if (jitter && $urandom_range(0, 5) == 0) begin
      cmd.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    cmd.valid <= 1'b1;
    cmd.command <= c;
    cmd.node_a <= NODE_W'(a);
    cmd.node_b <= NODE_W'(b);
    do @(negedge clk); while (!cmd.ready);
    @(posedge clk);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_nodes(input int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_NODE_COUNT * 4);
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic grow_tree(input int n, input int spread);
    int p;
    for (int i = 2; i <= n; i++) begin
      p = $urandom_range((i - 1 - spread < 1) ? 1 : i - 1 - spread, i - 1);
      if ($urandom_range(0, 1)) issue(CMD_ADD, i, p);
      else issue(CMD_ADD, p, i);
    end
  endtask

  task automatic ask(input int n, input int count);
    int a, b;
    for (int i = 0; i < count; i++) begin
      a = $urandom_range(1, n);
      b = $urandom_range(1, n);
      if ($urandom_range(0, 19) == 0) a = $urandom_range(0, 2047);
      if ($urandom_range(0, 19) == 0) b = $urandom_range(0, 2047);
      issue(CMD_QUERY, a, b);
    end
  endtask

  initial begin
    int n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd.valid = 1'b0;
    cmd.command = CMD_CLEAR;
    cmd.node_a = '0;
    cmd.node_b = '0;
    jitter = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    issue(CMD_QUERY, 1, 1);
    issue(CMD_QUERY, 0, 1);
    issue(CMD_ADD, 1, 1);
    issue(CMD_QUERY, 2047, 1);
    issue(CMD_BUILD, 0, 0);
    issue(CMD_QUERY, 1, 1);
    drain();
    set_nodes(0);
    issue(CMD_QUERY, 1, 1);
    issue(CMD_ADD, 2, 1);
    drain();
    set_nodes(2047);
    issue(CMD_ADD, 1024, 1);
    issue(CMD_ADD, 1025, 1);
    issue(CMD_QUERY, 1024, 1);
    issue(CMD_CLEAR, 0, 0);
    issue(CMD_ADD, 1, 2);
    issue(CMD_ADD, 2, 3);
    issue(CMD_ADD, 3, 1);
    issue(CMD_ADD, 1, 2);
    issue(CMD_ADD, 3, 4);
    issue(CMD_BUILD, 0, 0);
    issue(CMD_QUERY, 4, 2);
    issue(CMD_QUERY, 3, 3);
    issue(CMD_QUERY, 5, 1);
    issue(CMD_QUERY, 5, 6);
    issue(CMD_QUERY, 1024, 1023);
    drain();

    set_nodes(1024);
    issue(CMD_CLEAR, 0, 0);
    grow_tree(1024, 2);
    issue(CMD_ADD, 5, 9);
    issue(CMD_BUILD, 0, 0);
    issue(CMD_QUERY, 1024, 1);
    issue(CMD_QUERY, 1, 1024);
    ask(1024, 100);
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      if (ph >= 7) jitter = 1'b0;
      case ($urandom_range(0, 4))
        0: n = 2;
        1: n = $urandom_range(3, 8);
        default: n = $urandom_range(9, 64);
      endcase
      if (ph == 4) n = $urandom_range(100, 300);
      set_nodes(n);
      issue(CMD_CLEAR, 0, 0);
      issue(CMD_QUERY, 1, n);
      grow_tree(n, $urandom_range(0, n));
      for (int e = 0; e < 4; e++)
        issue(CMD_ADD, $urandom_range(0, 1) ? 0 : $urandom_range(n + 1, 2047),
              $urandom_range(1, n));
      if (ph % 3 == 1)
        for (int e = 0; e < 3; e++)
          issue(CMD_ADD, $urandom_range(1, n), $urandom_range(1, n));
      issue(CMD_BUILD, 0, 0);
      ask(n, (n > 64) ? 40 : 60);
      issue(CMD_ADD, 1, n);
      issue(CMD_QUERY, n, 1);
      drain();
    end

    repeat (50) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
